// File: src/rc4_stream_cipher_top_defines.svh
// ----------------------------------------------------------------------------
// rc4 stream cipher assertion macros
// clocked concurrent assertion helpers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RC4_ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("rc4 assertion failed");
`define RC4_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("rc4 assertion failed");
`else
`define RC4_ASSERT_IMPL(lbl, clk, rstn, pre, post)
`define RC4_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif

`endif

// File: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4 package
// sizes, datapath select codes, control word and microcode rom
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int PERM_DEPTH    = 256;
  localparam int PERM_AW       = 8;
  localparam int KEY_BYTES_MAX = 256;
  localparam int KEY_AW        = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
  localparam int COUNT_W       = $clog2(KEY_BYTES_MAX + 1);

  // perm ram read address source
  typedef enum logic [2:0] {
    RA_INEXT,
    RA_JSUM,
    RA_TSUM,
    RA_T,
    RA_N,
    RA_ACCSUM
  } ra_e;

  // perm ram write address source
  typedef enum logic [1:0] {
    WA_I,
    WA_J,
    WA_N,
    WA_ACC
  } wa_e;

  // perm ram write data source
  typedef enum logic [1:0] {
    WD_RDATA,
    WD_A,
    WD_N
  } wd_e;

  // branch condition
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_NOT_LAST,
    C_OUT_BUSY,
    C_DISPATCH
  } cond_e;

  // microcode step addresses
  typedef enum logic [3:0] {
    U_IDLE,
    U_DATA1,
    U_DATA2,
    U_DATA3,
    U_FILL_R,
    U_FILL_K,
    U_KSA1,
    U_KSA2,
    U_KSA3,
    U_KSA4
  } upc_e;

  typedef struct packed {
    ra_e   ra;
    wa_e   wa;
    wd_e   wd;
    logic  we;
    logic  ld_a;
    logic  ld_j;
    logic  ld_bt;
    logic  ld_acc;
    logic  n_inc;
    logic  k_step;
    logic  out_ld;
    cond_e cond;
    upc_e  tgt_t;
    upc_e  tgt_f;
  } ctl_t;

  function automatic ctl_t rom_word(input upc_e pc);
    ctl_t w;
    w.ra     = RA_INEXT;
    w.wa     = WA_I;
    w.wd     = WD_RDATA;
    w.we     = 1'b0;
    w.ld_a   = 1'b0;
    w.ld_j   = 1'b0;
    w.ld_bt  = 1'b0;
    w.ld_acc = 1'b0;
    w.n_inc  = 1'b0;
    w.k_step = 1'b0;
    w.out_ld = 1'b0;
    w.cond   = C_ALWAYS;
    w.tgt_t  = U_IDLE;
    w.tgt_f  = U_IDLE;
    unique case (pc)
      U_IDLE: begin
        w.cond  = C_DISPATCH;
        w.tgt_t = U_DATA1;
        w.tgt_f = U_FILL_K;
      end
      U_DATA1: begin
        w.ra    = RA_JSUM;
        w.ld_a  = 1'b1;
        w.ld_j  = 1'b1;
        w.tgt_t = U_DATA2;
      end
      U_DATA2: begin
        w.ra    = RA_TSUM;
        w.we    = 1'b1;
        w.wa    = WA_I;
        w.wd    = WD_RDATA;
        w.ld_bt = 1'b1;
        w.tgt_t = U_DATA3;
      end
      U_DATA3: begin
        w.ra     = RA_T;
        w.we     = 1'b1;
        w.wa     = WA_J;
        w.wd     = WD_A;
        w.out_ld = 1'b1;
        w.cond   = C_OUT_BUSY;
        w.tgt_t  = U_DATA3;
        w.tgt_f  = U_IDLE;
      end
      U_FILL_R: begin
        w.we    = 1'b1;
        w.wa    = WA_N;
        w.wd    = WD_N;
        w.n_inc = 1'b1;
        w.cond  = C_NOT_LAST;
        w.tgt_t = U_FILL_R;
        w.tgt_f = U_IDLE;
      end
      U_FILL_K: begin
        w.we    = 1'b1;
        w.wa    = WA_N;
        w.wd    = WD_N;
        w.n_inc = 1'b1;
        w.cond  = C_NOT_LAST;
        w.tgt_t = U_FILL_K;
        w.tgt_f = U_KSA1;
      end
      U_KSA1: begin
        w.ra    = RA_N;
        w.tgt_t = U_KSA2;
      end
      U_KSA2: begin
        w.ra     = RA_ACCSUM;
        w.ld_a   = 1'b1;
        w.ld_acc = 1'b1;
        w.tgt_t  = U_KSA3;
      end
      U_KSA3: begin
        w.we    = 1'b1;
        w.wa    = WA_N;
        w.wd    = WD_RDATA;
        w.tgt_t = U_KSA4;
      end
      U_KSA4: begin
        w.we     = 1'b1;
        w.wa     = WA_ACC;
        w.wd     = WD_A;
        w.n_inc  = 1'b1;
        w.k_step = 1'b1;
        w.cond   = C_NOT_LAST;
        w.tgt_t  = U_KSA1;
        w.tgt_f  = U_IDLE;
      end
      default: begin
        w.tgt_t = U_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: src/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4 generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/rc4_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// rc4 stream cipher top
// rc4 key schedule and keystream generator run by a microcoded sequencer
// ----------------------------------------------------------------------------
// Key bytes and data bytes share one request channel. A key byte not flagged
// last leaves the sequencer idle for the next request; the last one also
// starts the key schedule: a pass that reloads the identity permutation, then
// 256 schedule steps of KSA1 to KSA4, during which no request is taken. A data
// byte is accepted and then runs three steps, set by the single read port of
// the permutation ram: three reads and two writes per byte. After reset a pass
// loads the identity permutation before the first request is taken. The
// result sits in an output register, so a new request is taken while the last
// result waits; a data byte then holds in its final step until that clears.
`include "rc4_stream_cipher_top_defines.svh"

module rc4_stream_cipher_top
  import rc4_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] byte_value_i,
  input  logic       key_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o
);

  localparam logic [PERM_AW-1:0] N_LAST = PERM_AW'(PERM_DEPTH - 1);

  upc_e upc_q, upc_d;
  ctl_t ctl;

  logic [7:0]         i_q, i_d, j_q, j_d, a_q, a_d, b_q, b_d, t_q, t_d;
  logic [7:0]         acc_q, acc_d, value_q, value_d, out_q, out_d;
  logic [PERM_AW-1:0] n_q, n_d;
  logic [KEY_AW-1:0]  kidx_q, kidx_d;
  logic [COUNT_W-1:0] len_q, len_d, count_q, count_d, count_next;
  logic               out_valid_q, out_valid_d;

  logic               in_acc, out_busy, key_store, key_wrap, key_go;
  logic [7:0]         perm_rd, perm_ra, perm_wa, perm_wd, key_rd, acc_sum, ks;

  assign ctl        = rom_word(upc_q);
  assign in_ready_o = (upc_q == U_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign key_go     = in_acc && !kind_i && key_last_i;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign key_store  = (count_q < COUNT_W'(KEY_BYTES_MAX));
  assign count_next = count_q + COUNT_W'(key_store);
  assign key_wrap   = ((COUNT_W'(kidx_q) + COUNT_W'(1)) == len_q);
  assign acc_sum    = acc_q + perm_rd + key_rd;

  // keystream byte with forwarding of the swap just written
  always_comb begin
    if (t_q == j_q) begin
      ks = a_q;
    end else if (t_q == i_q) begin
      ks = b_q;
    end else begin
      ks = perm_rd;
    end
  end

  always_comb begin
    unique case (ctl.ra)
      RA_INEXT:  perm_ra = i_q + 8'd1;
      RA_JSUM:   perm_ra = j_q + perm_rd;
      RA_TSUM:   perm_ra = a_q + perm_rd;
      RA_T:      perm_ra = t_q;
      RA_N:      perm_ra = n_q;
      RA_ACCSUM: perm_ra = acc_sum;
      default:   perm_ra = n_q;
    endcase
    unique case (ctl.wa)
      WA_I:    perm_wa = i_q;
      WA_J:    perm_wa = j_q;
      WA_N:    perm_wa = n_q;
      WA_ACC:  perm_wa = acc_q;
      default: perm_wa = n_q;
    endcase
    unique case (ctl.wd)
      WD_RDATA: perm_wd = perm_rd;
      WD_A:     perm_wd = a_q;
      WD_N:     perm_wd = n_q;
      default:  perm_wd = n_q;
    endcase
  end

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(PERM_DEPTH)
  ) u_perm_ram (
    .clk_i  (clk_i),
    .we_i   (ctl.we),
    .waddr_i(perm_wa),
    .wdata_i(perm_wd),
    .raddr_i(perm_ra),
    .rdata_o(perm_rd)
  );

  rc4_ram #(
    .WIDTH(8),
    .DEPTH(KEY_BYTES_MAX)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc && !kind_i && key_store),
    .waddr_i(count_q[KEY_AW-1:0]),
    .wdata_i(byte_value_i),
    .raddr_i(kidx_q),
    .rdata_o(key_rd)
  );

  // sequencer next step
  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:   upc_d = ctl.tgt_t;
      C_NOT_LAST: upc_d = (n_q != N_LAST) ? ctl.tgt_t : ctl.tgt_f;
      C_OUT_BUSY: upc_d = out_busy ? ctl.tgt_t : ctl.tgt_f;
      C_DISPATCH: begin
        if (in_acc && kind_i) begin
          upc_d = ctl.tgt_t;
        end else if (in_acc && key_last_i) begin
          upc_d = ctl.tgt_f;
        end else begin
          upc_d = U_IDLE;
        end
      end
      default:    upc_d = U_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    i_d         = i_q;
    j_d         = j_q;
    a_d         = a_q;
    b_d         = b_q;
    t_d         = t_q;
    acc_d       = acc_q;
    value_d     = value_q;
    out_d       = out_q;
    n_d         = n_q;
    kidx_d      = kidx_q;
    len_d       = len_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (in_acc) begin
      if (kind_i) begin
        i_d     = i_q + 8'd1;
        value_d = byte_value_i;
      end else begin
        count_d = count_next;
        if (key_last_i) begin
          len_d   = count_next;
          count_d = '0;
          i_d     = '0;
          j_d     = '0;
          acc_d   = '0;
          kidx_d  = '0;
        end
      end
    end
    if (ctl.ld_a) begin
      a_d = perm_rd;
    end
    if (ctl.ld_j) begin
      j_d = j_q + perm_rd;
    end
    if (ctl.ld_bt) begin
      b_d = perm_rd;
      t_d = a_q + perm_rd;
    end
    if (ctl.ld_acc) begin
      acc_d = acc_sum;
    end
    if (ctl.n_inc) begin
      n_d = n_q + PERM_AW'(1);
    end
    if (ctl.k_step) begin
      kidx_d = key_wrap ? '0 : kidx_q + KEY_AW'(1);
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctl.out_ld && !out_busy) begin
      out_valid_d = 1'b1;
      out_d       = value_q ^ ks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_FILL_R;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    t_q     <= t_d;
    acc_q   <= acc_d;
    value_q <= value_d;
    out_q   <= out_d;
    kidx_q  <= kidx_d;
    len_q   <= len_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q;

  `RC4_ASSERT_IMPL(a_out_from_data3, clk_i, rst_ni, $rose(out_valid_q), $past(upc_q == U_DATA3))
  `RC4_ASSERT_NEXT(a_data_dispatch, clk_i, rst_ni, in_acc && kind_i, upc_q == U_DATA1)
  `RC4_ASSERT_NEXT(a_key_dispatch, clk_i, rst_ni, key_go, (upc_q == U_FILL_K) && (n_q == '0))

endmodule
